/* design/lraf_pkg.sv */
package lraf_pkg;

  localparam int SCREEN_WIDTH_DEF  = 640;
  localparam int SCREEN_HEIGHT_DEF = 480;

  localparam logic [7:0] CHAN_MAX = 8'd255;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic signed [11:0] start_x;
    logic signed [11:0] start_y;
    logic signed [11:0] end_x;
    logic signed [11:0] end_y;
    logic [7:0]         add_red;
    logic [7:0]         add_green;
    logic [7:0]         add_blue;
    logic [18:0]        read_address;
  } lraf_in_t;

  typedef struct packed {
    logic [7:0]  pixel_red;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_blue;
    logic [12:0] pixels_plotted;
  } lraf_out_t;

  // One stepped point of a line, as handed from the stepper to the pixel pipeline.
  typedef struct packed {
    logic               valid;
    logic               last;
    logic               visible;
    logic signed [12:0] x;
    logic signed [12:0] y;
  } lraf_point_t;

  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? CHAN_MAX : s[7:0];
  endfunction

endpackage

/* design/lraf_ram.sv */
module lraf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/lraf_stepper.sv */
module lraf_stepper #(
  parameter int SCREEN_WIDTH  = lraf_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = lraf_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [11:0] x0,
  input  logic signed [11:0] y0,
  input  logic signed [11:0] x1,
  input  logic signed [11:0] y1,
  output lraf_pkg::lraf_point_t pt
);
  import lraf_pkg::*;

  localparam logic signed [12:0] WIDTH_S  = 13'(SCREEN_WIDTH);
  localparam logic signed [12:0] HEIGHT_S = 13'(SCREEN_HEIGHT);

  logic               active;
  logic signed [12:0] x, y;
  logic [12:0]        err;
  logic [11:0]        rem;
  logic [11:0]        major, minor;
  logic               xmaj, sxn, syn;

  logic signed [12:0] dx, dy;
  logic [11:0]        adx, ady;
  logic [12:0]        e_sum;
  logic               ovf, step_x, step_y;

  // Setup from the endpoints.
  always_comb begin
    dx  = {x1[11], x1} - {x0[11], x0};
    dy  = {y1[11], y1} - {y0[11], y0};
    adx = dx[12] ? 12'(-dx) : dx[11:0];
    ady = dy[12] ? 12'(-dy) : dy[11:0];
  end

  // Error accumulator step.
  always_comb begin
    e_sum  = err + {1'b0, minor};
    ovf    = e_sum >= {1'b0, major};
    step_x = xmaj || ovf;
    step_y = !xmaj || ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
    end else if (active && rem == '0) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= {x0[11], x0};
      y    <= {y0[11], y0};
      xmaj <= adx >= ady;
      sxn  <= dx[12];
      syn  <= dy[12];
      if (adx >= ady) begin
        major <= adx;
        minor <= ady;
        rem   <= adx;
        err   <= {2'b00, adx[11:1]};
      end else begin
        major <= ady;
        minor <= adx;
        rem   <= ady;
        err   <= {2'b00, ady[11:1]};
      end
    end else if (active) begin
      err <= ovf ? e_sum - {1'b0, major} : e_sum;
      rem <= rem - 12'd1;
      if (step_x) begin
        x <= sxn ? x - 13'sd1 : x + 13'sd1;
      end
      if (step_y) begin
        y <= syn ? y - 13'sd1 : y + 13'sd1;
      end
    end
  end

  always_comb begin
    pt.valid   = active;
    pt.last    = rem == '0;
    pt.visible = (x >= 13'sd0) && (x < WIDTH_S) && (y >= 13'sd0) && (y < HEIGHT_S);
    pt.x       = x;
    pt.y       = y;
  end

endmodule

/* design/line_raster_additive_framebuffer.sv */
// Channel  | Valid      | Stall      | Payload               | Meaning
// command  | cmd_valid  | cmd_stall  | cmd (lraf_in_t)       | draw a line or read-and-clear
// response | rsp_valid  | rsp_stall  | rsp (lraf_out_t)      | one result per command
//
// A draw command plots major + 1 points before the next command is accepted, where
// major is the larger of |end_x - start_x| and |end_y - start_y|: the stepper emits one
// point per cycle and each point costs one read-modify-write of the frame RAM port.
// A read command is a single point. Reset starts a clearing pass over all
// SCREEN_WIDTH * SCREEN_HEIGHT pixels (307200 by default), during which cmd_stall is high.
// A finished result waits in the response register; one more result may wait in a
// holding register, and only a full holding register blocks the next command.
module line_raster_additive_framebuffer #(
  parameter int SCREEN_WIDTH  = lraf_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = lraf_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  lraf_pkg::lraf_in_t  cmd,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output lraf_pkg::lraf_out_t rsp
);
  import lraf_pkg::*;

  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(SCREEN_WIDTH);
  localparam int YW    = $clog2(SCREEN_HEIGHT);
  localparam logic [AW-1:0] WIDTH_A  = AW'(SCREEN_WIDTH);
  localparam logic [AW-1:0] LAST_A   = AW'(DEPTH - 1);
  localparam logic [31:0]   DEPTH_32 = 32'(DEPTH);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;

  logic [1:0]    state;
  logic [AW-1:0] clear_addr;
  logic          accept;

  // Command context held for the whole transaction.
  logic          opcode_r;
  logic [7:0]    col_r, col_g, col_b;
  logic [12:0]   count;

  lraf_point_t   pt;

  // Address stage: RAM read is issued from here.
  logic          s1_valid, s1_last, s1_vis;
  logic [AW-1:0] s1_addr;
  // Update stage: read data is back, write the new pixel.
  logic          s2_valid, s2_last, s2_vis;
  logic [AW-1:0] s2_addr;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [23:0]   ram_wdata, ram_rdata;
  logic [23:0]   mod_pixel;

  logic          res_valid;
  lraf_out_t     res;
  logic          pend_valid;
  lraf_out_t     pend;
  logic          rsp_free;

  assign cmd_stall = (state != ST_IDLE) || pend_valid;
  assign accept    = cmd_valid && !cmd_stall;

  // Sequencer: clear pass after reset, then one command at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clear_addr <= clear_addr + AW'(1);
          if (clear_addr == LAST_A) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          // release as the last pixel is written back
          if (s2_valid && s2_last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      opcode_r <= cmd.opcode;
      col_r    <= cmd.add_red;
      col_g    <= cmd.add_green;
      col_b    <= cmd.add_blue;
    end
  end

  lraf_stepper #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_stepper (
    .clk  (clk),
    .rst  (rst),
    .start(accept && cmd.opcode == OP_DRAW),
    .x0   (cmd.start_x),
    .y0   (cmd.start_y),
    .x1   (cmd.end_x),
    .y1   (cmd.end_y),
    .pt   (pt)
  );

  // Address stage: a read command enters here directly as a single point.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && cmd.opcode == OP_READ) begin
      s1_valid <= 1'b1;
    end else begin
      s1_valid <= pt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd.opcode == OP_READ) begin
      s1_last <= 1'b1;
      s1_vis  <= 32'(cmd.read_address) < DEPTH_32;
      s1_addr <= AW'(cmd.read_address);
    end else begin
      s1_last <= pt.last;
      s1_vis  <= pt.visible;
      s1_addr <= AW'(pt.x[XW-1:0]) + AW'(pt.y[YW-1:0]) * WIDTH_A;
    end
  end

  // Update stage. Consecutive points of a line never share a pixel, and the next
  // command starts only after the last write, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_last <= s1_last;
    s2_vis  <= s1_vis;
    s2_addr <= s1_addr;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      count <= '0;
    end else if (s2_valid && s2_vis) begin
      count <= count + 13'd1;
    end
  end

  assign mod_pixel = (opcode_r == OP_READ) ? 24'd0 :
                     {sat_add(ram_rdata[23:16], col_r),
                      sat_add(ram_rdata[15:8],  col_g),
                      sat_add(ram_rdata[7:0],   col_b)};

  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clear_addr;
      ram_wdata = 24'd0;
    end else begin
      ram_we    = s2_valid && s2_vis;
      ram_waddr = s2_addr;
      ram_wdata = mod_pixel;
    end
  end

  lraf_ram #(
    .WIDTH(24),
    .DEPTH(DEPTH)
  ) u_frame (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(s1_addr),
    .rdata(ram_rdata)
  );

  // Result of the transaction, formed on its last point.
  always_comb begin
    res_valid = s2_valid && s2_last;
    if (opcode_r == OP_READ) begin
      res.pixel_red      = s2_vis ? ram_rdata[23:16] : 8'd0;
      res.pixel_green    = s2_vis ? ram_rdata[15:8]  : 8'd0;
      res.pixel_blue     = s2_vis ? ram_rdata[7:0]   : 8'd0;
      res.pixels_plotted = 13'd0;
    end else begin
      res.pixel_red      = 8'd0;
      res.pixel_green    = 8'd0;
      res.pixel_blue     = 8'd0;
      res.pixels_plotted = count + {12'd0, s2_vis};
    end
  end

  // Response register plus one holding slot; only a full holding slot holds off new commands.
  assign rsp_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (rsp_free) begin
      if (pend_valid) begin
        rsp_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else begin
        rsp_valid <= res_valid;
      end
    end else if (res_valid) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_free) begin
      if (pend_valid) begin
        rsp <= pend;
      end else if (res_valid) begin
        rsp <= res;
      end
    end else if (res_valid) begin
      pend <= res;
    end
  end

endmodule

/* design/lraf_checker.sv */
module lraf_checker (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_stall,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input lraf_pkg::lraf_out_t rsp
);

  // Reset empties the response side.
  a_rst_rsp: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Reset starts the clearing pass, so commands are held off.
  a_rst_stall: assert property (@(posedge clk) rst |=> cmd_stall)
    else $error("command taken during clearing pass");

  // One transaction at a time: never two accepts in a row.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall)
    else $error("back-to-back command acceptance");

  // A draw reports no color, a read reports no count.
  a_rsp_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.pixels_plotted == 13'd0) ||
                  (rsp.pixel_red == 8'd0 && rsp.pixel_green == 8'd0 &&
                   rsp.pixel_blue == 8'd0))
    else $error("response mixes color and count");

  // A stalled response holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

endmodule

bind line_raster_additive_framebuffer lraf_checker u_lraf_checker (.*);

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import lraf_pkg::*;

  localparam int FB_W      = SCREEN_WIDTH_DEF;
  localparam int FB_H      = SCREEN_HEIGHT_DEF;
  localparam int FB_PIXELS = FB_W * FB_H;
  localparam int RANDOM_CMDS = 930;
  // Stop producing idle and stall bursts once the backlog drops below this many commands.
  localparam int CALM_TAIL   = 120;

  typedef struct {
    lraf_in_t c;
    bit       drain_first;  // hold this command until every response is back
  } queued_cmd_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  lraf_in_t  cmd = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  lraf_out_t rsp;

  // Shadow copy of the frame store, packed as {red, green, blue}; black at reset.
  bit [23:0] frame_img [FB_PIXELS];

  queued_cmd_t cmd_backlog [$];
  lraf_out_t   rsp_due [$];
  int          n_predicted = 0;
  int          n_checked = 0;
  int          mismatches = 0;
  logic        calm = 1'b0;

  line_raster_additive_framebuffer dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: frame store shadow and line stepper
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] brighten(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  // Apply one command to the shadow frame store and return the response it owes.
  function automatic lraf_out_t run_command(input lraf_in_t c);
    lraf_out_t res;
    int x, y, x1, y1, dx, dy, sx, sy, adx, ady;
    int major, minor, err, mx, my, nx, ny, plotted, idx;
    logic [23:0] px;
    res = '0;
    if (c.opcode == OP_DRAW) begin
      x  = $signed(c.start_x);
      y  = $signed(c.start_y);
      x1 = $signed(c.end_x);
      y1 = $signed(c.end_y);
      dx = x1 - x;
      dy = y1 - y;
      sx = (dx >= 0) ? 1 : -1;
      sy = (dy >= 0) ? 1 : -1;
      adx = (dx >= 0) ? dx : -dx;
      ady = (dy >= 0) ? dy : -dy;
      // Step along the longer axis every point; step the other on error overflow.
      if (adx >= ady) begin
        major = adx; minor = ady;
        mx = sx; my = 0; nx = 0; ny = sy;
      end else begin
        major = ady; minor = adx;
        mx = 0; my = sy; nx = sx; ny = 0;
      end
      err = major / 2;
      plotted = 0;
      for (int i = 0; i <= major; i++) begin
        // Skip points off screen; they neither write nor count.
        if (x >= 0 && x < FB_W && y >= 0 && y < FB_H) begin
          idx = x + y * FB_W;
          px  = frame_img[idx];
          frame_img[idx] = {brighten(px[23:16], c.add_red),
                            brighten(px[15:8], c.add_green),
                            brighten(px[7:0], c.add_blue)};
          plotted++;
        end
        err += minor;
        if (err >= major) begin
          err -= major;
          x += nx;
          y += ny;
        end
        x += mx;
        y += my;
      end
      res.pixels_plotted = plotted[12:0];
    end else if (c.read_address < FB_PIXELS) begin
      // Return the pixel, then clear it to black; out of range reads give black.
      px = frame_img[c.read_address];
      res.pixel_red   = px[23:16];
      res.pixel_green = px[15:8];
      res.pixel_blue  = px[7:0];
      frame_img[c.read_address] = '0;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Command builders; fields that the opcode ignores carry random values
  // ---------------------------------------------------------------------------

  function automatic lraf_in_t line_cmd(input int x0, input int y0, input int x1,
                                        input int y1, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b);
    lraf_in_t c;
    c.opcode       = OP_DRAW;
    c.start_x      = x0[11:0];
    c.start_y      = y0[11:0];
    c.end_x        = x1[11:0];
    c.end_y        = y1[11:0];
    c.add_red      = r;
    c.add_green    = g;
    c.add_blue     = b;
    c.read_address = 19'($urandom_range(0, 19'h7FFFF));
    return c;
  endfunction

  function automatic lraf_in_t read_cmd(input int addr);
    lraf_in_t c;
    c.opcode       = OP_READ;
    c.start_x      = 12'($urandom_range(0, 4095));
    c.start_y      = 12'($urandom_range(0, 4095));
    c.end_x        = 12'($urandom_range(0, 4095));
    c.end_y        = 12'($urandom_range(0, 4095));
    c.add_red      = 8'($urandom_range(0, 255));
    c.add_green    = 8'($urandom_range(0, 255));
    c.add_blue     = 8'($urandom_range(0, 255));
    c.read_address = addr[18:0];
    return c;
  endfunction

  task automatic record_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v)
      record_error($sformatf("%s mismatch: expected %0d, got %0d", name, want_v, got_v));
  endtask

  // ---------------------------------------------------------------------------
  // Command driver: predict on each accepted transaction, then present the next
  // ---------------------------------------------------------------------------

  int send_gap = 0;

  always @(posedge clk) begin : drive_cmds
    lraf_in_t    nxt;
    queued_cmd_t q;
    logic        nv;
    logic        drained;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        rsp_due.push_back(run_command(cmd));
        n_predicted++;
      end
      // Count a response accepted at this same edge as already home.
      drained = (n_predicted == n_checked + ((rsp_valid && !rsp_stall) ? 1 : 0));
      calm <= (cmd_backlog.size() < CALM_TAIL);
      // Hold a stalled transaction untouched; otherwise the slot is free.
      if (!cmd_valid || !cmd_stall) begin
        nv  = 1'b0;
        nxt = cmd;
        if (send_gap > 0) begin
          send_gap--;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 5);  // start an idle burst
        end else if (cmd_backlog.size() != 0 &&
                     (!cmd_backlog[0].drain_first || drained)) begin
          q   = cmd_backlog.pop_front();
          nxt = q.c;
          nv  = 1'b1;
        end
        cmd_valid <= nv;
        cmd       <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Response monitor: check against the oldest prediction, stall in bursts
  // ---------------------------------------------------------------------------

  int hold_left = 0;

  always @(posedge clk) begin : watch_rsp
    lraf_out_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (rsp_due.size() == 0) begin
          record_error($sformatf("response with nothing pending: %h", rsp));
        end else begin
          want = rsp_due.pop_front();
          compare_field("pixel_red", int'(want.pixel_red), int'(rsp.pixel_red));
          compare_field("pixel_green", int'(want.pixel_green), int'(rsp.pixel_green));
          compare_field("pixel_blue", int'(want.pixel_blue), int'(rsp.pixel_blue));
          compare_field("pixels_plotted", int'(want.pixels_plotted),
                        int'(rsp.pixels_plotted));
          n_checked <= n_checked + 1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 5);  // start a stall burst
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    int bx, by, sel, rx, ry, addr, span;
    int x0, y0, x1, y1;
    logic [7:0] r, g, b;

    // Directed commands: endpoints, zero length, full-range diagonals, screen edges,
    // saturation, reads in and out of range, off-screen lines, lines in several directions.
    cmd_backlog.push_back('{line_cmd(0, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF), 1'b0});
    cmd_backlog.push_back('{read_cmd(0), 1'b0});
    cmd_backlog.push_back('{read_cmd(0), 1'b0});
    cmd_backlog.push_back('{line_cmd(-1, -1, -1, -1, 8'h10, 8'h20, 8'h30), 1'b0});
    cmd_backlog.push_back('{line_cmd(-2048, -2048, 2047, 2047, 8'h01, 8'h02, 8'h03), 1'b0});
    cmd_backlog.push_back('{line_cmd(2047, -2048, -2048, 2047, 8'h80, 8'h80, 8'h80), 1'b0});
    cmd_backlog.push_back('{line_cmd(0, 479, 639, 479, 8'd200, 8'd100, 8'd0), 1'b0});
    cmd_backlog.push_back('{line_cmd(639, 479, 0, 479, 8'd100, 8'd200, 8'd255), 1'b0});
    cmd_backlog.push_back('{read_cmd(FB_PIXELS - 1), 1'b1});
    cmd_backlog.push_back('{read_cmd(FB_PIXELS), 1'b0});
    cmd_backlog.push_back('{read_cmd(19'h7FFFF), 1'b0});
    cmd_backlog.push_back('{line_cmd(639, 0, 639, 479, 8'h55, 8'hAA, 8'h0F), 1'b0});
    cmd_backlog.push_back('{read_cmd(639), 1'b0});
    cmd_backlog.push_back('{line_cmd(5, 100, 3, 10, 8'h07, 8'h00, 8'hF0), 1'b0});
    cmd_backlog.push_back('{line_cmd(10, 10, -5, 3, 8'h33, 8'h44, 8'h55), 1'b0});
    cmd_backlog.push_back('{line_cmd(640, 0, 700, 479, 8'hFF, 8'hFF, 8'hFF), 1'b0});
    cmd_backlog.push_back('{read_cmd(3 + 10 * FB_W), 1'b0});
    cmd_backlog.push_back('{line_cmd(0, 480, 639, 2047, 8'hFF, 8'h00, 8'hFF), 1'b0});
    cmd_backlog.push_back('{line_cmd(0, 1, 20, 5, 8'h00, 8'h00, 8'h00), 1'b0});
    cmd_backlog.push_back('{read_cmd(FB_W), 1'b0});
    cmd_backlog.push_back('{read_cmd(5 + 100 * FB_W), 1'b0});

    // Random commands clustered in a window that moves every 60 commands, so lines
    // overlap, saturate and cross screen edges and reads find drawn pixels.
    bx = 0;
    by = 0;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 6))
          0: begin bx = 0;   by = 0;   end
          1: begin bx = 608; by = 448; end
          2: begin bx = -20; by = -20; end
          3: begin bx = 620; by = -10; end
          4: begin bx = -10; by = 460; end
          5: begin bx = 300; by = 200; end
          default: begin bx = 100; by = 400; end
        endcase
      end
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        if (sel < 30) begin
          rx = bx + $urandom_range(0, 47);
          ry = by + $urandom_range(0, 47);
          rx = (rx < 0) ? 0 : (rx >= FB_W) ? FB_W - 1 : rx;
          ry = (ry < 0) ? 0 : (ry >= FB_H) ? FB_H - 1 : ry;
          addr = rx + ry * FB_W;
        end else if (sel < 33) begin
          addr = $urandom_range(0, 19'h7FFFF);
        end else begin
          addr = $urandom_range(FB_PIXELS, 19'h7FFFF);
        end
        cmd_backlog.push_back('{read_cmd(addr), (n % 250 == 125)});
      end else begin
        span = $urandom_range(0, 1) ? 255 : 40;
        r = 8'($urandom_range(0, span));
        g = 8'($urandom_range(0, span));
        b = 8'($urandom_range(0, span));
        x0 = bx + $urandom_range(0, 47);
        y0 = by + $urandom_range(0, 47);
        x1 = bx + $urandom_range(0, 47);
        y1 = by + $urandom_range(0, 47);
        // Keep long lines rare: each steps up to 4k points.
        if (sel >= 94) begin
          x1 = $urandom_range(0, 4095) - 2048;
          y1 = $urandom_range(0, 4095) - 2048;
        end
        if (sel >= 97) begin
          x0 = $urandom_range(0, 4095) - 2048;
          y0 = $urandom_range(0, 4095) - 2048;
        end
        cmd_backlog.push_back('{line_cmd(x0, y0, x1, y1, r, g, b), (n % 250 == 125)});
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Drain: everything sent, every prediction answered, then let the pipe settle.
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || cmd_valid || n_checked != n_predicted);
    repeat (50) @(negedge clk);
    if (rsp_due.size() != 0)
      record_error($sformatf("%0d responses never arrived", rsp_due.size()));

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hang guard: covers the clearing pass and worst-case long lines.
  initial begin
    #400_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* line_raster_additive_framebuffer.f */
design/lraf_pkg.sv
design/lraf_ram.sv
design/lraf_stepper.sv
design/line_raster_additive_framebuffer.sv
design/lraf_checker.sv
verif/testbench.sv
